@@ hw/rtl/nearest_rank_percentile_stats_top_assert.svh @@
// Assertion macros for the percentile statistics top level.
`ifndef NEAREST_RANK_PERCENTILE_STATS_TOP_ASSERT_SVH
`define NEAREST_RANK_PERCENTILE_STATS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("nrps: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("nrps: next-cycle check failed");

`endif

@@ hw/rtl/nrps_pkg.sv @@
// Shared types and constants for the percentile statistics block.
`default_nettype none

package nrps_pkg;

  localparam int SampleW = 64;
  localparam int CountOutW = 9;

  localparam int PctMedian = 50;
  localparam int Pct95 = 95;
  localparam int Pct99 = 99;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RANK,
    ST_SCAN,
    ST_OUT
  } nrps_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [SampleW-1:0] din;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/nrps_cell.sv @@
// One cell of the sorted sample chain.
`default_nettype none

module nrps_cell
  import nrps_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [SampleW-1:0] left_val,
  input  wire logic               left_gt,
  input  wire logic [SampleW-1:0] right_val,
  output logic      [SampleW-1:0] val,
  output logic                    gt
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [SampleW-1:0] val_r;
  logic [SampleW-1:0] val_nxt;
  logic               occ;

  // Occupied cells hold the ascending prefix of the set.
  assign occ = (count > MyIdx);
  assign gt  = occ && (val_r > ctrl.din);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CELL_INSERT: begin
        // Larger entries move right; the first larger or empty slot takes din.
        if (left_gt) begin
          val_nxt = left_val;
        end else if (gt || !occ) begin
          val_nxt = ctrl.din;
        end
      end
      CELL_SHIFT: val_nxt = right_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/nrps_rank.sv @@
// Nearest-rank index unit: registered (pct*n + 99)/100 - 1.
`default_nettype none

module nrps_rank
  import nrps_pkg::*;
#(
  parameter int PCT   = 50,
  parameter int CNT_W = 9,
  parameter int IDX_W = 8
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [CNT_W-1:0] count,
  output logic      [IDX_W-1:0] idx
);

  // x < 2^XW; reciprocal error e < 2^7 so x*e < 2^Shift keeps the floor exact.
  localparam int XW    = CNT_W + 7;
  localparam int Shift = XW + 7;
  localparam int KW    = Shift - 6;
  localparam int PW    = XW + KW;
  localparam longint KVal = ((longint'(1) << Shift) + 64'd99) / 64'd100;
  localparam logic [KW-1:0] Recip = KW'(KVal);

  logic [XW-1:0]    x;
  logic [PW-1:0]    prod;
  logic [CNT_W:0]   rank;
  logic [CNT_W:0]   rank_m1;
  logic [IDX_W-1:0] idx_r;

  assign x       = XW'(count) * XW'(PCT) + XW'(99);
  assign prod    = PW'(x) * PW'(Recip);
  assign rank    = prod[PW-1:Shift];
  assign rank_m1 = rank - 1'b1;
  assign idx     = idx_r;

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r <= rank_m1[IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_rank_percentile_stats_top.sv @@
// Top level of the nearest-rank percentile statistics block.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | request   | in_valid/in_stall  | sample_value, has_sample, last
//   out     | result    | out_valid/out_stall| count, min, max, median, p95, p99, latest,
//           |           |                    | overflowed
//
// A sample request is inserted at the edge that takes it: the chain shifts larger
// entries right by one cell and drops the new sample into the gap.
// A request with last set shows its result once the rank units have loaded
// (ST_RANK) and, for a non-empty set, the chain has shifted toward cell 0
// (ST_SCAN) while the percentile taps are captured.
// in_stall is high from the last request until the result is taken.
// Reset is synchronous (rst_n low); the sample store is not cleared, only
// the count, latest sample and overflow flag; there is no clearing pass.
// out_stall holds the result registers; nothing else moves meanwhile.
`default_nettype none
`include "nearest_rank_percentile_stats_top_assert.svh"

module nearest_rank_percentile_stats_top
  import nrps_pkg::*;
#(
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SampleW-1:0]   in_sample_value,
  input  wire logic                 in_has_sample,
  input  wire logic                 in_last,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [CountOutW-1:0] out_sample_count,
  output logic      [SampleW-1:0]   out_minimum,
  output logic      [SampleW-1:0]   out_maximum,
  output logic      [SampleW-1:0]   out_median,
  output logic      [SampleW-1:0]   out_p95,
  output logic      [SampleW-1:0]   out_p99,
  output logic      [SampleW-1:0]   out_latest,
  output logic                      out_overflowed
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CntW-1:0] CapCount = CntW'(MAX_SAMPLES);

  nrps_state_t state_r, state_nxt;

  logic [CntW-1:0]    count_r;
  logic [SampleW-1:0] latest_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic [IdxW-1:0]    pos_r;

  // result registers (payload, no reset)
  logic [CntW-1:0]    res_count_r;
  logic [SampleW-1:0] res_min_r, res_max_r, res_med_r, res_p95_r, res_p99_r;
  logic [SampleW-1:0] res_latest_r;
  logic               res_ovf_r;

  logic               in_acc;
  logic               full;
  logic [CntW-1:0]    cnt_m1;
  logic [IdxW-1:0]    last_idx;
  logic               scan_end;
  logic [SampleW-1:0] head;
  logic               rank_load;
  logic [IdxW-1:0]    med_idx, p95_idx, p99_idx;
  logic [CntW+CountOutW-1:0] count_ext;
  cell_ctrl_t         cell_ctrl;

  logic [SampleW-1:0] chain_val [MAX_SAMPLES];
  logic               chain_gt  [MAX_SAMPLES];

  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CapCount);
  assign cnt_m1   = count_r - 1'b1;
  assign last_idx = cnt_m1[IdxW-1:0];
  assign scan_end = (pos_r == last_idx);
  assign head     = chain_val[0];

  // ---------------------------------------------------------------- cell chain
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic [SampleW-1:0] left_v;
    logic               left_g;
    logic [SampleW-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_v = chain_val[i-1];
      assign left_g = chain_gt[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_end
      assign right_v = chain_val[i];
    end else begin : g_inner
      assign right_v = chain_val[i+1];
    end

    nrps_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .count     (count_r),
      .left_val  (left_v),
      .left_gt   (left_g),
      .right_val (right_v),
      .val       (chain_val[i]),
      .gt        (chain_gt[i])
    );
  end

  // ---------------------------------------------------------------- rank units
  assign rank_load = (state_r == ST_RANK);

  nrps_rank #(.PCT(PctMedian), .CNT_W(CntW), .IDX_W(IdxW)) u_rank_med (
    .clk (clk), .load (rank_load), .count (count_r), .idx (med_idx)
  );
  nrps_rank #(.PCT(Pct95), .CNT_W(CntW), .IDX_W(IdxW)) u_rank_p95 (
    .clk (clk), .load (rank_load), .count (count_r), .idx (p95_idx)
  );
  nrps_rank #(.PCT(Pct99), .CNT_W(CntW), .IDX_W(IdxW)) u_rank_p99 (
    .clk (clk), .load (rank_load), .count (count_r), .idx (p99_idx)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_acc && in_last) state_nxt = ST_RANK;
      ST_RANK: state_nxt = (count_r == '0) ? ST_OUT : ST_SCAN;
      ST_SCAN: if (scan_end) state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall      = 1'b1;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.din = in_sample_value;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        // a sample past capacity only raises the overflow flag
        if (in_acc && in_has_sample && !full) cell_ctrl.op = CELL_INSERT;
      end
      ST_SCAN: cell_ctrl.op = CELL_SHIFT;
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      latest_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (in_acc && in_has_sample) begin
            if (!full) begin
              count_r  <= count_r + 1'b1;
              latest_r <= in_sample_value;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_RANK: begin
          pos_r <= '0;
          if (count_r == '0) begin
            out_valid_r <= 1'b1;
            latest_r    <= '0;
            ovf_r       <= 1'b0;
          end
        end
        ST_SCAN: begin
          pos_r <= pos_r + 1'b1;
          if (scan_end) begin
            // set closes here; the result registers carry it from now on
            out_valid_r <= 1'b1;
            count_r     <= '0;
            latest_r    <= '0;
            ovf_r       <= 1'b0;
          end
        end
        ST_OUT: if (!out_stall) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- result regs
  always_ff @(posedge clk) begin
    if (state_r == ST_RANK) begin
      res_count_r  <= count_r;
      res_latest_r <= latest_r;
      res_ovf_r    <= ovf_r;
      if (count_r == '0) begin
        // empty set: everything reads zero
        res_min_r    <= '0;
        res_max_r    <= '0;
        res_med_r    <= '0;
        res_p95_r    <= '0;
        res_p99_r    <= '0;
        res_latest_r <= '0;
        res_ovf_r    <= 1'b0;
      end
    end else if (state_r == ST_SCAN) begin
      // head of the chain is the sample of rank pos_r
      if (pos_r == '0)     res_min_r <= head;
      if (pos_r == med_idx) res_med_r <= head;
      if (pos_r == p95_idx) res_p95_r <= head;
      if (pos_r == p99_idx) res_p99_r <= head;
      if (scan_end)         res_max_r <= head;
    end
  end

  assign count_ext        = {{CountOutW{1'b0}}, res_count_r};
  assign out_valid        = out_valid_r;
  assign out_sample_count = count_ext[CountOutW-1:0];
  assign out_minimum      = res_min_r;
  assign out_maximum      = res_max_r;
  assign out_median       = res_med_r;
  assign out_p95          = res_p95_r;
  assign out_p99          = res_p99_r;
  assign out_latest       = res_latest_r;
  assign out_overflowed   = res_ovf_r;

  // ---------------------------------------------------------------- assertions
  `NRPS_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CapCount)
  `NRPS_ASSERT_IMP(a_ovf_full, clk, rst_n, ovf_r, count_r == CapCount)
  `NRPS_ASSERT_IMP(a_result_state, clk, rst_n, out_valid_r, state_r == ST_OUT)
  `NRPS_ASSERT_IMP(a_scan_pos, clk, rst_n, state_r == ST_SCAN, CntW'(pos_r) < count_r)
  `NRPS_ASSERT_NXT(a_last_rank, clk, rst_n, in_acc && in_last, state_r == ST_RANK)

endmodule

`default_nettype wire

@@ verif/tb_nearest_rank_percentile_stats_top.sv @@
// Self-checking testbench for the nearest-rank percentile statistics block.
module tb_nearest_rank_percentile_stats_top
  import nrps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES    = 256;
  // Request count for the whole run.
  localparam int TARGET_ITEMS   = 1350;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES    = 400;
  // Quiet tail after the last result: room for the worst set plus margin.
  localparam int DRAIN_CYCLES   = MAX_SAMPLES + 40;
  // Longest correct quiet stretch: full-set ranking behind the hold-off.
  localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + MAX_SAMPLES + 16);

  // One result of a closed set, as the block should report it.
  typedef struct packed {
    logic [CountOutW-1:0] count;
    logic [SampleW-1:0]   minimum;
    logic [SampleW-1:0]   maximum;
    logic [SampleW-1:0]   median;
    logic [SampleW-1:0]   p95;
    logic [SampleW-1:0]   p99;
    logic [SampleW-1:0]   latest;
    logic                 overflowed;
  } set_stats_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [SampleW-1:0]   in_sample_value = '0;
  logic                 in_has_sample   = 1'b0;
  logic                 in_last         = 1'b0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [CountOutW-1:0] out_sample_count;
  logic [SampleW-1:0]   out_minimum;
  logic [SampleW-1:0]   out_maximum;
  logic [SampleW-1:0]   out_median;
  logic [SampleW-1:0]   out_p95;
  logic [SampleW-1:0]   out_p99;
  logic [SampleW-1:0]   out_latest;
  logic                 out_overflowed;

  nearest_rank_percentile_stats_top #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_has_sample   (in_has_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_count(out_sample_count),
    .out_minimum     (out_minimum),
    .out_maximum     (out_maximum),
    .out_median      (out_median),
    .out_p95         (out_p95),
    .out_p99         (out_p99),
    .out_latest      (out_latest),
    .out_overflowed  (out_overflowed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: the samples of the open set, kept ascending.
  // ---------------------------------------------------------------------
  logic [SampleW-1:0] ranked_samples [MAX_SAMPLES];
  int unsigned        held_count  = 0;
  logic [SampleW-1:0] latest_held = '0;
  logic               dropped_flag = 1'b0;
  set_stats_t         pending_stats [$];

  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;   // both sides run without gaps
  bit          hold_req    = 1'b0;   // asks the sink for the long hold-off

  // Nearest-rank position: max(1, ceil(pct * n / 100)) - 1.
  function automatic int unsigned rank_position(int unsigned n, int unsigned pct);
    int unsigned rank;
    rank = (pct * n + 99) / 100;
    if (rank < 1) begin
      rank = 1;
    end
    return rank - 1;
  endfunction

  // Applies one accepted request to the predictor; a closing request
  // queues the expected statistics and reopens an empty set.
  function automatic void absorb_request(logic [SampleW-1:0] value, logic has, logic lst);
    int unsigned slot;
    set_stats_t  stats;
    if (has) begin
      if (held_count < MAX_SAMPLES) begin
        // Insertion sort; equal values land after the ones already held.
        slot = held_count;
        while (slot > 0 && ranked_samples[slot-1] > value) begin
          ranked_samples[slot] = ranked_samples[slot-1];
          slot--;
        end
        ranked_samples[slot] = value;
        held_count++;
        latest_held = value;
      end else begin
        // Store full: sample dropped, latest untouched.
        dropped_flag = 1'b1;
      end
    end
    if (lst) begin
      stats = '0;
      if (held_count != 0) begin
        stats.count      = held_count[CountOutW-1:0];
        stats.minimum    = ranked_samples[0];
        stats.maximum    = ranked_samples[held_count-1];
        stats.median     = ranked_samples[rank_position(held_count, PctMedian)];
        stats.p95        = ranked_samples[rank_position(held_count, Pct95)];
        stats.p99        = ranked_samples[rank_position(held_count, Pct99)];
        stats.latest     = latest_held;
        stats.overflowed = dropped_flag;
      end
      pending_stats.insert(pending_stats.size(), stats);
      held_count   = 0;
      latest_held  = '0;
      dropped_flag = 1'b0;
    end
  endfunction

  function automatic void compare_field(string name, logic [SampleW-1:0] want,
                                        logic [SampleW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compares the result on the ports with the oldest expectation.
  function automatic void check_result();
    set_stats_t want;
    if (pending_stats.size() == 0) begin
      $error("result with no expectation pending");
      error_count++;
      return;
    end
    want = pending_stats.pop_front();
    compare_field("sample_count", SampleW'(want.count), SampleW'(out_sample_count));
    compare_field("minimum", want.minimum, out_minimum);
    compare_field("maximum", want.maximum, out_maximum);
    compare_field("median", want.median, out_median);
    compare_field("p95", want.p95, out_p95);
    compare_field("p99", want.p99, out_p99);
    compare_field("latest", want.latest, out_latest);
    compare_field("overflowed", SampleW'(want.overflowed), SampleW'(out_overflowed));
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge, before any update
  // of that edge lands, so requests and results are seen exactly once.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        absorb_request(in_sample_value, in_has_sample, in_last);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog: read at the falling edge, away from the monitor's updates.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result sink. After each result it may draw a random stall that it holds
  // against the next result once that one is valid. On request it
  // holds off for HOLD_CYCLES so the block backs up and stalls its input.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        wait_left = 0;
      end else if (out_valid && !out_stall) begin
        wait_left = no_idle ? 0 : $urandom_range(0, 3);
        out_stall <= (wait_left != 0);
      end else if (out_valid && out_stall) begin
        if (wait_left > 1) begin
          wait_left--;
        end else begin
          wait_left = 0;
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------

  // Offers one request after a random gap and returns at the edge that
  // takes it. Valid stays high into the next call when it has no gap.
  task automatic send_request(input logic [SampleW-1:0] value, input logic has,
                              input logic lst);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_has_sample   <= has;
    in_last         <= lst;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Mix of full-width values, extremes and a narrow range for duplicates.
  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} | {1'b1, {(SampleW-1){1'b0}}};
      3, 4: return SampleW'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One set of n_samples samples with occasional sample-free noise.
  // close_alone ends it with a separate sample-free closing request.
  task automatic send_set(input int unsigned n_samples, input bit close_alone);
    int unsigned sent;
    bit          separate;
    sent     = 0;
    separate = close_alone || (n_samples == 0);
    while (sent < n_samples) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(random_sample(), 1'b0, 1'b0);
      end else begin
        sent++;
        send_request(random_sample(), 1'b1, !separate && sent == n_samples);
      end
    end
    if (separate) begin
      send_request(random_sample(), 1'b0, 1'b1);
    end
  endtask

  // Drops valid and waits, at falling edges, until every result is in.
  task automatic settle();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_stats.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty sets, lone samples, extremes, duplicates, closing without sample.
  task automatic test_directed_edges();
    // empty set, value ignored
    send_request(64'hDEAD_BEEF_0123_4567, 1'b0, 1'b1);
    // sample-free noise, then an empty close
    send_request('1, 1'b0, 1'b0);
    send_request('1, 1'b0, 1'b1);
    // lone samples at both extremes, closed on the sample itself
    send_request('1, 1'b1, 1'b1);
    send_request('0, 1'b1, 1'b1);
    // unordered extremes and equal values; latest is the last one loaded
    send_request('1, 1'b1, 1'b0);
    send_request('0, 1'b1, 1'b0);
    send_request(64'd5, 1'b1, 1'b0);
    send_request(64'd5, 1'b1, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_request(64'd1, 1'b1, 1'b0);
    send_request(64'd5, 1'b1, 1'b0);
    send_request(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    send_request(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    send_request('0, 1'b0, 1'b1);
  endtask

  // Exactly full, then past capacity with the close on a dropped sample.
  task automatic test_capacity_overflow();
    send_set(MAX_SAMPLES, 1'b0);
    send_set(MAX_SAMPLES + 3, 1'b0);
  endtask

  // Long output hold-off while sets keep coming: input must stall.
  task automatic test_output_backpressure();
    settle();
    hold_req = 1'b1;
    @(posedge clk);
    repeat (3) send_set($urandom_range(8, 30), 1'b0);
  endtask

  // Stretch with no gaps on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (12) send_set($urandom_range(0, 8), $urandom_range(0, 1) == 1);
    no_idle = 1'b0;
  endtask

  // Random sets, mostly small, now and then near or past capacity.
  task automatic test_random_sets();
    int unsigned size_pick;
    int unsigned n;
    while (items_sent < TARGET_ITEMS) begin
      size_pick = $urandom_range(0, 99);
      if (size_pick < 80) begin
        n = $urandom_range(0, 12);
      end else if (size_pick < 99) begin
        n = $urandom_range(13, 60);
      end else begin
        n = $urandom_range(MAX_SAMPLES - 16, MAX_SAMPLES + 6);
      end
      send_set(n, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_capacity_overflow();
    test_output_backpressure();
    test_back_to_back();
    test_random_sets();
    settle();
    // Quiet tail: catches any result nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/nrps_pkg.sv
hw/rtl/nrps_cell.sv
hw/rtl/nrps_rank.sv
hw/rtl/nearest_rank_percentile_stats_top.sv
verif/tb_nearest_rank_percentile_stats_top.sv
